// ----- rtl/core/cpio_pkg.sv -----
// ----------------------------------------------------------------------------
// cpio newc parser package
// Shared phase codes, result kinds, constant tables and the front-to-back
// result record.
// ----------------------------------------------------------------------------
package cpio_pkg;

    localparam int HDR_LEN   = 110;
    localparam int ALIGN_LOG = 2;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_HEADER    = 3'd1,
        PH_NAME      = 3'd2,
        PH_NAME_TAIL = 3'd3,
        PH_NAME_PAD  = 3'd4,
        PH_DATA      = 3'd5,
        PH_DATA_PAD  = 3'd6,
        PH_HALT      = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ENTRY   = 2'd0,
        KIND_DATA    = 2'd1,
        KIND_TRAILER = 2'd2,
        KIND_BAD     = 2'd3
    } kind_t;

    // one result record handed from the front to the back
    typedef struct packed {
        kind_t       kind;
        logic [31:0] file_size;
        logic [31:0] name_size;
        logic [31:0] data_offset;
        logic        name_match;
        logic [7:0]  data_value;
        logic        last_data;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    function automatic logic [7:0] magic_char(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = 8'h30;
            3'd1:    r = 8'h37;
            3'd2:    r = 8'h30;
            3'd3:    r = 8'h37;
            3'd4:    r = 8'h30;
            3'd5:    r = 8'h31;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] trailer_char(input logic [3:0] i);
        logic [7:0] r;
        case (i)
            4'd0:    r = 8'h54;
            4'd1:    r = 8'h52;
            4'd2:    r = 8'h41;
            4'd3:    r = 8'h49;
            4'd4:    r = 8'h4C;
            4'd5:    r = 8'h45;
            4'd6:    r = 8'h52;
            4'd7:    r = 8'h21;
            4'd8:    r = 8'h21;
            4'd9:    r = 8'h21;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] r;
        if (c >= 8'h30 && c <= 8'h39)      r = c[3:0];
        else if (c >= 8'h41 && c <= 8'h46) r = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) r = 4'(c - 8'h57);
        else                               r = 4'd0;
        return r;
    endfunction

endpackage

// ----- rtl/core/cpio_front.sv -----
// ----------------------------------------------------------------------------
// cpio parser front end
// Walks the archive byte by byte, decodes the header, compares the name and
// produces at most one result record per byte.
// ----------------------------------------------------------------------------
module cpio_front import cpio_pkg::*; #(
    parameter int NAME_BYTES = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                in_byte,
    input  logic                      in_start,
    input  logic [8*NAME_BYTES-1:0]   want_name,
    input  logic [4:0]                target_len,
    input  logic                      emit_en,
    output logic                      res_valid,
    output result_t                   res,
    input  logic                      res_ready
);

    phase_t      phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] fsize_reg, fsize_next;
    logic [31:0] nsize_reg, nsize_next;
    logic [31:0] offs_reg, offs_next;
    logic        teq_reg, teq_next;
    logic        treq_reg, treq_next;
    logic        emit_reg, emit_next;

    logic        fire;
    logic [31:0] offs_inc;
    logic [31:0] cnt1;
    logic [31:0] aligned;
    logic [7:0]  tbyte;
    logic        in_hex;

    assign in_ready = res_ready;
    assign fire     = in_valid && in_ready;

    // target byte at the current name position
    always_comb begin
        tbyte = 8'h00;
        for (int i = 0; i < NAME_BYTES; i++) begin
            if (count_reg == 32'(i)) tbyte = want_name[8*i +: 8];
        end
    end

    // per-byte parse step
    always_comb begin
        phase_t ph;
        logic   close;
        logic   halt_next;
        ph         = phase_reg;
        offs_inc   = offs_reg;
        acc_next   = acc_reg;
        emit_next  = emit_reg;
        count_next = count_reg;
        fsize_next = fsize_reg;
        nsize_next = nsize_reg;
        teq_next   = teq_reg;
        treq_next  = treq_reg;
        res_valid  = 1'b0;
        res        = '0;
        close      = 1'b0;
        halt_next  = 1'b0;
        cnt1       = 32'd0;
        aligned    = 32'd0;
        in_hex     = 1'b0;
        if (in_start) begin
            ph         = PH_HEADER;
            count_next = 32'd0;
            offs_inc   = 32'd0;
            acc_next   = 32'd0;
            emit_next  = 1'b0;
        end
        phase_next = ph;
        if (ph != PH_IDLE && ph != PH_HALT) begin
            offs_inc = offs_inc + 32'd1;
        end
        cnt1 = count_next + 32'd1;
        unique case (ph)
            PH_HEADER: begin
                if (count_next < 32'd6 && in_byte != magic_char(count_next[2:0])) begin
                    res_valid  = 1'b1;
                    res.kind   = KIND_BAD;
                    phase_next = PH_HALT;
                end else begin
                    if (count_next == 32'd54 || count_next == 32'd94) acc_next = 32'd0;
                    in_hex = (count_next >= 32'd54 && count_next < 32'd62)
                          || (count_next >= 32'd94 && count_next < 32'd102);
                    if (in_hex) acc_next = {acc_next[27:0], hex_value(in_byte)};
                    if (count_next == 32'd61) fsize_next = acc_next;
                    if (count_next == 32'd101) nsize_next = acc_next;
                    count_next = cnt1;
                    if (count_next == 32'(HDR_LEN)) begin
                        teq_next   = 1'b1;
                        treq_next  = 1'b1;
                        count_next = 32'd0;
                        if (nsize_next == 32'd0) begin
                            teq_next  = (target_len == 5'd0);
                            treq_next = 1'b0;
                            close     = 1'b1;
                        end else begin
                            phase_next = PH_NAME;
                        end
                    end
                end
            end
            PH_NAME, PH_NAME_TAIL: begin
                if (ph == PH_NAME) begin
                    if (in_byte == 8'h00) begin
                        teq_next   = teq_reg && count_next == 32'(target_len);
                        treq_next  = treq_reg && count_next == 32'd10;
                        phase_next = PH_NAME_TAIL;
                    end else begin
                        teq_next  = teq_reg && count_next < 32'(target_len)
                                 && (count_next >= 32'(NAME_BYTES) || in_byte == tbyte);
                        treq_next = treq_reg && count_next < 32'd10
                                 && in_byte == trailer_char(count_next[3:0]);
                    end
                end
                count_next = cnt1;
                if (cnt1 == nsize_reg) begin
                    // length check only when no zero byte ended the name
                    if (phase_next == PH_NAME) begin
                        teq_next  = teq_next && nsize_reg == 32'(target_len);
                        treq_next = treq_next && nsize_reg == 32'd10;
                    end
                    close = 1'b1;
                end
            end
            PH_NAME_PAD: begin
                if (offs_inc[ALIGN_LOG-1:0] == '0) begin
                    count_next = 32'd0;
                    if (fsize_reg == 32'd0) halt_next = 1'b1;
                    else phase_next = PH_DATA;
                end
            end
            PH_DATA: begin
                count_next = cnt1;
                if (emit_reg) begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_DATA;
                    res.file_size   = fsize_reg;
                    res.name_size   = nsize_reg;
                    res.data_offset = acc_reg;
                    res.name_match  = 1'b1;
                    res.data_value  = in_byte;
                    res.last_data   = (cnt1 == fsize_reg);
                end
                if (cnt1 == fsize_reg) halt_next = 1'b1;
            end
            PH_DATA_PAD: begin
                if (offs_inc[ALIGN_LOG-1:0] == '0) begin
                    phase_next = PH_HEADER;
                    count_next = 32'd0;
                end
            end
            PH_IDLE, PH_HALT: begin
                phase_next = ph;
            end
            default: phase_next = PH_IDLE;
        endcase

        // name finished: give entry or trailer result
        if (close) begin
            aligned  = (offs_inc + 32'd3) & ~32'd3;
            acc_next = aligned;
            res_valid       = 1'b1;
            res.file_size   = fsize_next;
            res.name_size   = nsize_next;
            res.data_offset = aligned;
            if (treq_next) begin
                res.kind   = KIND_TRAILER;
                phase_next = PH_HALT;
            end else begin
                res.kind       = KIND_ENTRY;
                res.name_match = teq_next;
                emit_next      = teq_next && emit_en;
                if (offs_inc[ALIGN_LOG-1:0] != '0) begin
                    phase_next = PH_NAME_PAD;
                end else begin
                    count_next = 32'd0;
                    if (fsize_next == 32'd0) halt_next = 1'b1;
                    else phase_next = PH_DATA;
                end
            end
        end

        // end of data section
        if (halt_next) begin
            if (emit_next) begin
                emit_next  = 1'b0;
                phase_next = PH_HALT;
            end else if (offs_inc[ALIGN_LOG-1:0] != '0) begin
                phase_next = PH_DATA_PAD;
            end else begin
                phase_next = PH_HEADER;
                count_next = 32'd0;
            end
        end
        offs_next = offs_inc;
        res_valid = res_valid && fire;
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            acc_reg   <= '0;
            fsize_reg <= '0;
            nsize_reg <= '0;
            offs_reg  <= '0;
            teq_reg   <= 1'b1;
            treq_reg  <= 1'b1;
            emit_reg  <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            fsize_reg <= fsize_next;
            nsize_reg <= nsize_next;
            offs_reg  <= offs_next;
            teq_reg   <= teq_next;
            treq_reg  <= treq_next;
            emit_reg  <= emit_next;
        end
    end

`ifndef SYNTH
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HALT && fire && !in_start) |=> phase_reg == PH_HALT)
        else $error("halt left without archive start");
    a_no_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE && !in_start) |-> !res_valid)
        else $error("result while idle");
    a_emit_only_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.kind == KIND_DATA) |-> emit_reg)
        else $error("data result without emission");
`endif

endmodule

// ----- rtl/core/cpio_queue.sv -----
// ----------------------------------------------------------------------------
// cpio result queue
// Two-entry queue between the parser front end and the output stage.
// ----------------------------------------------------------------------------
module cpio_queue import cpio_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    wr_valid,
    input  result_t wr_data,
    output logic    wr_ready,
    output logic    rd_valid,
    output result_t rd_data,
    input  logic    rd_ready
);

    result_t     mem_reg [2];
    logic        wptr_reg, rptr_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wptr_reg] <= wr_data;
    end

    // pointers and fill
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
        end
    end

`ifndef SYNTH
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2) else $error("queue overfilled");
    a_fill_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("fill count lost a push");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wptr_reg == rptr_reg)
        else $error("pointers disagree with fill");
`endif

endmodule

// ----- rtl/core/cpio_newc_stream_parser.sv -----
// ----------------------------------------------------------------------------
// cpio newc stream parser
// Top level: configuration registers, parser front end and result queue.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one archive byte per transaction, tuser = archive start.
//   m_axis carries one result per transaction: entry record at the end of
//   each name, data bytes of the matching file in emit mode, a trailer
//   record, or a bad magic record.
//   Configuration is written through cfg_we/cfg_addr/cfg_wdata while idle.
// Timing:
//   One byte per cycle while the queue has room. A result enters the queue when
//   its byte is taken and is offered on m_axis from there. The front end is held
//   whenever the two-entry queue is full, so s_axis_tready falls only when
//   m_axis has stalled for two results.
// Reset:
//   aresetn clears the registers and the queue; the parser waits for a byte
//   with archive start set. Results already queued wait through a stall.
// ----------------------------------------------------------------------------
module cpio_newc_stream_parser import cpio_pkg::*; #(
    parameter int NAME_BYTES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // archive_byte
    input  logic         s_axis_tuser,   // archive_start
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // file_size[31:0], name_size[63:32], data_offset[95:64], name_match[96],
    // data_value[104:97], last_data[105], zero fill[111:106]
    output logic [111:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // result_kind
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [63:0]  cfg_wdata
);

    localparam logic [1:0] REG_NAME_LOW  = 2'd0;
    localparam logic [1:0] REG_NAME_HIGH = 2'd1;
    localparam logic [1:0] REG_NAME_LEN  = 2'd2;
    localparam logic [1:0] REG_EMIT      = 2'd3;

    logic [63:0] name_low_reg, name_high_reg;
    logic [4:0]  name_len_reg;
    logic        emit_reg;
    logic [127:0] name_full;

    logic    f_valid, q_ready, q_valid;
    result_t f_res, q_res;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_low_reg  <= '0;
            name_high_reg <= '0;
            name_len_reg  <= '0;
            emit_reg      <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_NAME_LOW:  name_low_reg  <= cfg_wdata;
                REG_NAME_HIGH: name_high_reg <= cfg_wdata;
                REG_NAME_LEN:  name_len_reg  <= cfg_wdata[4:0];
                REG_EMIT:      emit_reg      <= cfg_wdata[0];
                default:       ;
            endcase
        end
    end

    assign name_full = {name_high_reg, name_low_reg};

    cpio_front #(.NAME_BYTES(NAME_BYTES)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_byte     (s_axis_tdata),
        .in_start    (s_axis_tuser),
        .want_name   (name_full[8*NAME_BYTES-1:0]),
        .target_len  (name_len_reg),
        .emit_en     (emit_reg),
        .res_valid   (f_valid),
        .res         (f_res),
        .res_ready   (q_ready)
    );

    cpio_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_data  (f_res),
        .wr_ready (q_ready),
        .rd_valid (q_valid),
        .rd_data  (q_res),
        .rd_ready (m_axis_tready)
    );

    // output packing
    assign m_axis_tvalid = q_valid;
    assign m_axis_tuser  = q_res.kind;
    assign m_axis_tdata  = {6'd0, q_res.last_data, q_res.data_value, q_res.name_match,
                            q_res.data_offset, q_res.name_size, q_res.file_size};

`ifndef SYNTH
    a_kind_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == KIND_BAD) |-> m_axis_tdata == '0)
        else $error("bad magic record carries data");
    a_data_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == KIND_DATA) |-> m_axis_tdata[96])
        else $error("data byte without match");
    a_trailer_nomatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == KIND_TRAILER) |-> !m_axis_tdata[96])
        else $error("trailer flagged as match");
`endif

endmodule

// ----- bench/cpio_newc_stream_parser_test.sv -----
// ----------------------------------------------------------------------------
// cpio newc stream parser testbench
// Builds cpio newc archives byte by byte (well-formed entries, trailers, bad
// magic, truncated streams, sloppy hex digits), streams them through s_axis
// under several idle/stall mixes, and checks every m_axis result against an
// in-bench model of the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpio_newc_stream_parser_test;
    import cpio_pkg::*;

    localparam logic [1:0] REG_NAME_LOW  = 2'd0;
    localparam logic [1:0] REG_NAME_HIGH = 2'd1;
    localparam logic [1:0] REG_NAME_LEN  = 2'd2;
    localparam logic [1:0] REG_EMIT      = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic [7:0] byte_q_t[$];

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_addr = '0;
    logic [63:0]  cfg_wdata = '0;

    cpio_newc_stream_parser dut (.*);

    always #2 aclk = ~aclk;

    // parser model state and its copy of the registers
    logic [63:0] tgt_lo, tgt_hi;
    logic [4:0]  tgt_len;
    logic        emit_mode;
    phase_t      ph;
    logic [31:0] ph_cnt, acc, fsize, nsize, offs;
    bit          tgt_eq, trl_eq, emitting;

    result_t expected_results[$];
    byte_q_t archive_q;
    int idle_pct, stall_pct;
    int errors, bytes_sent, results_seen, cycles;

    function automatic logic [7:0] magic_byte(input int i);
        string s;
        s = "070701";
        return s[i];
    endfunction

    function automatic logic [7:0] trailer_byte(input int i);
        string s;
        s = "TRAILER!!!";
        return s[i];
    endfunction

    function automatic logic [3:0] digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 4'(c - "0");
        if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
        if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
        return 4'd0;
    endfunction

    function automatic logic [7:0] tgt_byte(input logic [31:0] i);
        if (i < 8) return tgt_lo[8*i +: 8];
        return tgt_hi[8*(i-8) +: 8];
    endfunction

    function automatic result_t make_result(kind_t k, logic m, logic [7:0] v,
                                            logic l, bit sizes);
        result_t r;
        r.kind        = k;
        r.file_size   = sizes ? fsize : '0;
        r.name_size   = sizes ? nsize : '0;
        r.data_offset = sizes ? acc : '0;
        r.name_match  = m;
        r.data_value  = v;
        r.last_data   = l;
        return r;
    endfunction

    function automatic void goto_header();
        ph = PH_HEADER;
        ph_cnt = 0;
    endfunction

    function automatic void finish_data();
        if (emitting) begin
            emitting = 0;
            ph = PH_HALT;
        end else if (offs[1:0] != 0) begin
            ph = PH_DATA_PAD;
        end else begin
            goto_header();
        end
    endfunction

    function automatic void start_data();
        ph_cnt = 0;
        if (fsize == 0) finish_data();
        else ph = PH_DATA;
    endfunction

    function automatic result_t close_entry();
        result_t r;
        acc = (offs + 3) & ~32'd3;
        if (trl_eq) begin
            ph = PH_HALT;
            return make_result(KIND_TRAILER, 1'b0, 8'd0, 1'b0, 1);
        end
        r = make_result(KIND_ENTRY, tgt_eq, 8'd0, 1'b0, 1);
        emitting = tgt_eq && emit_mode;
        if (offs[1:0] != 0) ph = PH_NAME_PAD;
        else start_data();
        return r;
    endfunction

    // advance the model by one archive byte; returns 1 when a result is due
    function automatic bit predict_parse(input logic [7:0] b, input logic st,
                                         output result_t r);
        logic [31:0] c;
        r = '0;
        if (st) begin
            goto_header();
            offs = 0;
            acc = 0;
            emitting = 0;
        end
        if (ph == PH_IDLE || ph == PH_HALT) return 0;
        offs++;
        c = ph_cnt;
        case (ph)
            PH_HEADER: begin
                if (c < 6 && b != magic_byte(c)) begin
                    r = make_result(KIND_BAD, 1'b0, 8'd0, 1'b0, 0);
                    ph = PH_HALT;
                    return 1;
                end
                if (c == 54 || c == 94) acc = 0;
                if ((c >= 54 && c < 62) || (c >= 94 && c < 102))
                    acc = {acc[27:0], digit_of(b)};
                if (c == 61) fsize = acc;
                if (c == 101) nsize = acc;
                ph_cnt = c + 1;
                if (c == HDR_LEN - 1) begin
                    tgt_eq = 1;
                    trl_eq = 1;
                    ph_cnt = 0;
                    if (nsize == 0) begin
                        tgt_eq = (tgt_len == 0);
                        trl_eq = 0;
                        r = close_entry();
                        return 1;
                    end
                    ph = PH_NAME;
                end
                return 0;
            end
            PH_NAME, PH_NAME_TAIL: begin
                if (ph == PH_NAME) begin
                    if (b == 0) begin
                        tgt_eq = tgt_eq && c == tgt_len;
                        trl_eq = trl_eq && c == 10;
                        ph = PH_NAME_TAIL;
                    end else begin
                        tgt_eq = tgt_eq && c < tgt_len && (c >= 16 || b == tgt_byte(c));
                        trl_eq = trl_eq && c < 10 && b == trailer_byte(c);
                    end
                end
                ph_cnt = c + 1;
                if (ph_cnt == nsize) begin
                    if (ph == PH_NAME) begin
                        tgt_eq = tgt_eq && nsize == tgt_len;
                        trl_eq = trl_eq && nsize == 10;
                    end
                    r = close_entry();
                    return 1;
                end
                return 0;
            end
            PH_NAME_PAD: begin
                if (offs[1:0] == 0) start_data();
                return 0;
            end
            PH_DATA: begin
                bit due;
                due = 0;
                ph_cnt = c + 1;
                if (emitting) begin
                    r = make_result(KIND_DATA, 1'b1, b, ph_cnt == fsize, 1);
                    due = 1;
                end
                if (ph_cnt == fsize) finish_data();
                return due;
            end
            PH_DATA_PAD: begin
                if (offs[1:0] == 0) goto_header();
                return 0;
            end
            default: begin
                ph = PH_IDLE;
                return 0;
            end
        endcase
    endfunction

    // cycle counter and timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge aclk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            result_t want;
            result_t got;
            got.kind        = kind_t'(m_axis_tuser);
            got.file_size   = m_axis_tdata[31:0];
            got.name_size   = m_axis_tdata[63:32];
            got.data_offset = m_axis_tdata[95:64];
            got.name_match  = m_axis_tdata[96];
            got.data_value  = m_axis_tdata[104:97];
            got.last_data   = m_axis_tdata[105];
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result kind %0d", got.kind);
            end else begin
                want = expected_results.pop_front();
                if (got !== want || m_axis_tdata[111:106] !== '0) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp kind %0d fs %h ns %h off %h m %b v %h l %b / got kind %0d fs %h ns %h off %h m %b v %h l %b",
                                 want.kind, want.file_size, want.name_size, want.data_offset,
                                 want.name_match, want.data_value, want.last_data,
                                 got.kind, got.file_size, got.name_size, got.data_offset,
                                 got.name_match, got.data_value, got.last_data);
                end
            end
        end
    end

    // one byte transaction on s_axis, called at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic st);
        result_t r;
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= st;
        do @(posedge aclk); while (!s_axis_tready);
        if (predict_parse(b, st, r)) expected_results.push_back(r);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_archive();
        foreach (archive_q[i]) send_byte(archive_q[i], i == 0);
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    // wait for all results, then let the parser settle before a register write
    task automatic drain();
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] len, input logic emit);
        drain();
        cfg_we <= 1'b1;
        cfg_addr <= REG_NAME_LOW;  cfg_wdata <= lo;  @(negedge aclk);
        cfg_addr <= REG_NAME_HIGH; cfg_wdata <= hi;  @(negedge aclk);
        cfg_addr <= REG_NAME_LEN;  cfg_wdata <= 64'(len); @(negedge aclk);
        cfg_addr <= REG_EMIT;      cfg_wdata <= 64'(emit); @(negedge aclk);
        cfg_we <= 1'b0;
        tgt_lo = lo;
        tgt_hi = hi;
        tgt_len = len;
        emit_mode = emit;
    endtask

    // random target of the given length, garbage beyond the name
    task automatic configure_random(input int len, input logic emit);
        logic [63:0] lo, hi;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        for (int i = 0; i < len; i++) begin
            if (i < 8) lo[8*i +: 8] = 8'($urandom_range(1, 255));
            else hi[8*(i-8) +: 8] = 8'($urandom_range(1, 255));
        end
        configure(lo, hi, 5'(len), emit);
    endtask

    // eight hex digits, mixed case, zeros sometimes replaced by non-hex
    task automatic push_hex(input logic [31:0] v);
        logic [3:0] d;
        for (int k = 7; k >= 0; k--) begin
            d = v[4*k +: 4];
            if (d == 0 && $urandom_range(3) == 0)
                archive_q.push_back(8'($urandom_range(8'h67, 8'hff)));
            else if (d < 10)
                archive_q.push_back(8'("0" + d));
            else
                archive_q.push_back(8'(($urandom_range(1) ? "A" : "a") + d - 10));
        end
    endtask

    task automatic add_entry(input byte_q_t nm, input int name_len, input int file_len);
        for (int i = 0; i < 6; i++) archive_q.push_back(magic_byte(i));
        for (int f = 0; f < 13; f++)
            push_hex(f == 6 ? 32'(file_len) : f == 11 ? 32'(name_len) : $urandom);
        for (int i = 0; i < name_len; i++)
            archive_q.push_back(i < nm.size() ? nm[i] :
                                i == nm.size() ? 8'd0 : 8'($urandom));
        while (archive_q.size() % 4 != 0) archive_q.push_back(8'($urandom));
        for (int i = 0; i < file_len; i++) archive_q.push_back(8'($urandom));
        while (archive_q.size() % 4 != 0) archive_q.push_back(8'($urandom));
    endtask

    function automatic byte_q_t wanted_name();
        byte_q_t q;
        for (int i = 0; i < tgt_len; i++) q.push_back(tgt_byte(i));
        return q;
    endfunction

    function automatic byte_q_t trailer_name();
        byte_q_t q;
        for (int i = 0; i < 10; i++) q.push_back(trailer_byte(i));
        return q;
    endfunction

    function automatic byte_q_t random_name(input int len);
        byte_q_t q;
        for (int i = 0; i < len; i++) q.push_back(8'($urandom_range(1, 255)));
        return q;
    endfunction

    // entry name chosen among exact target, near misses of target and trailer, and noise
    task automatic add_random_entry(input int file_len);
        byte_q_t nm;
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2: nm = wanted_name();
            3: begin
                nm = wanted_name();
                if (nm.size() != 0) nm[$urandom_range(nm.size() - 1)] ^= 8'h01;
            end
            4: begin
                nm = wanted_name();
                nm.push_back(8'($urandom_range(1, 255)));
            end
            5: begin
                nm = trailer_name();
                nm[$urandom_range(9)] ^= 8'h20;
            end
            default: nm = random_name($urandom_range(0, 20));
        endcase
        // name size: exact with zero, without zero, or with tail bytes
        case ($urandom_range(3))
            0: add_entry(nm, nm.size(), file_len);
            1: add_entry(nm, nm.size() + 1 + $urandom_range(6), file_len);
            default: add_entry(nm, nm.size() + 1, file_len);
        endcase
    endtask

    task automatic test_directed();
        byte_q_t nm;
        configure(64'({"inu", 8'h74, "ini"}), 64'h0, 5'd5, 1'b0);
        // bytes before any archive start are ignored
        archive_q = '{8'h30, 8'h37};
        foreach (archive_q[i]) send_byte(archive_q[i], 1'b0);
        // bad magic at first and last magic position
        for (int p = 0; p < 6; p += 5) begin
            archive_q.delete();
            add_entry(trailer_name(), 11, 0);
            archive_q[p] = 8'hff;
            archive_q = archive_q[0 : 7];
            send_archive();
        end
        // match, zero name size, long name, nameless-zero name, trailer
        archive_q.delete();
        nm = '{"i", "n", "i", "t", "u"};
        add_entry(nm, 6, 7);
        add_entry(nm, 0, 3);
        add_entry(random_name(20), 21, 1);
        add_entry(nm, 5, 0);
        add_entry(trailer_name(), 11, 0);
        add_entry(nm, 6, 2);
        send_archive();
        // emit mode: zero-size match halts at once
        configure(64'({"inu", 8'h74, "ini"}), 64'h0, 5'd5, 1'b1);
        archive_q.delete();
        add_entry(nm, 6, 0);
        add_entry(nm, 6, 4);
        send_archive();
        // emit of data, restart mid-emission
        archive_q.delete();
        add_entry(random_name(3), 4, 2);
        add_entry(nm, 6, 9);
        archive_q = archive_q[0 : archive_q.size() - 8];
        send_archive();
        archive_q.delete();
        add_entry(nm, 6, 9);
        send_archive();
        // full-length and empty targets
        configure_random(16, 1'b0);
        archive_q.delete();
        add_entry(wanted_name(), 17, 5);
        add_entry(wanted_name(), 16, 1);
        send_archive();
        configure_random(0, 1'b1);
        archive_q.delete();
        add_entry(nm, 0, 5);
        send_archive();
    endtask

    task automatic test_random(input int idle, input int stall, input int budget);
        int stop_at;
        int n;
        idle_pct = idle;
        stall_pct = stall;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(3) == 0) begin
                n = $urandom_range(9);
                configure_random(n == 0 ? 0 : n == 1 ? 16 : $urandom_range(1, 15),
                                 1'($urandom_range(1)));
            end
            archive_q.delete();
            n = $urandom_range(1, 3);
            for (int e = 0; e < n; e++)
                add_random_entry($urandom_range(9) == 0 ? $urandom_range(13, 40)
                                                        : $urandom_range(0, 12));
            if ($urandom_range(9) < 6) add_entry(trailer_name(), 11, 0);
            if ($urandom_range(11) == 0)
                archive_q[110 * $urandom_range(0, 0) + $urandom_range(5)] ^=
                    8'(1 << $urandom_range(7));
            if ($urandom_range(9) == 0)
                archive_q = archive_q[0 : $urandom_range(1, archive_q.size() - 1)];
            send_archive();
        end
        drain();
    endtask

    initial begin
        errors = 0;
        bytes_sent = 0;
        results_seen = 0;
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        tgt_lo = '0;
        tgt_hi = '0;
        tgt_len = '0;
        emit_mode = 1'b0;
        ph = PH_IDLE;
        ph_cnt = 0;
        acc = 0;
        fsize = 0;
        nsize = 0;
        offs = 0;
        tgt_eq = 1;
        trl_eq = 1;
        emitting = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_random(0, 0, 100);
        test_random(53, 0, 100);
        test_random(0, 53, 100);
        test_random(24, 24, 100);
        repeat (20) @(negedge aclk);

        $display("streamed %0d archive bytes, checked %0d results", bytes_sent, results_seen);
        $display("covered entries, matches, emitted data, trailers, bad magic, restarts");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, expected_results.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
